// File: hdl/hpq_pkg.sv
// Shared types, codes and default sizes for the max-heap priority queue.
`default_nettype none

package hpq_pkg;

    localparam int HEAP_DEPTH_DEF = 1024;
    localparam int FREQ_BITS_DEF  = 16;
    localparam int TAG_BITS_DEF   = 16;

    typedef enum logic [1:0] {
        CMD_INSERT  = 2'd0,
        CMD_EXTRACT = 2'd1,
        CMD_FIND    = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_EX_RDL,
        S_EX_LD,
        S_DN_START,
        S_DN_RDR,
        S_DN_CMP,
        S_FD_CMP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic wr;
        logic rd;
    } t_mem_ctl;

endpackage

`default_nettype wire

// File: hdl/hpq_mem.sv
// Heap entry store: one write port, one registered read port.
`default_nettype none

module hpq_mem
    import hpq_pkg::*;
#(
    parameter int HEAP_DEPTH = HEAP_DEPTH_DEF,
    parameter int ENTRY_BITS = FREQ_BITS_DEF + TAG_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire t_mem_ctl                      i_ctl,
    input  wire logic [$clog2(HEAP_DEPTH)-1:0] i_waddr,
    input  wire logic [ENTRY_BITS-1:0]         i_wdata,
    input  wire logic [$clog2(HEAP_DEPTH)-1:0] i_raddr,
    output logic      [ENTRY_BITS-1:0]         o_rdata
);

    logic [ENTRY_BITS-1:0] r_mem [HEAP_DEPTH];
    logic [ENTRY_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hdl/hpq_seq.sv
// Command sequencer: sift up, sift down and linear search over the entry store.
`default_nettype none

module hpq_seq
    import hpq_pkg::*;
#(
    parameter int HEAP_DEPTH = HEAP_DEPTH_DEF,
    parameter int FREQ_BITS  = FREQ_BITS_DEF,
    parameter int TAG_BITS   = TAG_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic [1:0]                        i_cmd,
    input  wire logic [FREQ_BITS-1:0]              i_key_freq,
    input  wire logic [TAG_BITS-1:0]               i_item_tag,
    output logic                                   o_res_valid,
    input  wire logic                              i_res_take,
    output t_status                                o_status,
    output logic      [FREQ_BITS-1:0]              o_out_freq,
    output logic      [TAG_BITS-1:0]               o_out_tag,
    output logic      [$clog2(HEAP_DEPTH)-1:0]     o_found_pos,
    output logic      [$clog2(HEAP_DEPTH+1)-1:0]   o_fill_count,
    output t_mem_ctl                               o_mem_ctl,
    output logic      [$clog2(HEAP_DEPTH)-1:0]     o_waddr,
    output logic      [FREQ_BITS+TAG_BITS-1:0]     o_wdata,
    output logic      [$clog2(HEAP_DEPTH)-1:0]     o_raddr,
    input  wire logic [FREQ_BITS+TAG_BITS-1:0]     i_rdata
);

    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int DW = FREQ_BITS + TAG_BITS;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [AW-1:0]       r_pos, n_pos;
    logic [DW-1:0]       r_cur, n_cur;
    logic [DW-1:0]       r_best, n_best;
    logic [AW-1:0]       r_best_idx, n_best_idx;
    logic                r_best_child, n_best_child;
    logic                r_rc_ok, n_rc_ok;
    t_status             r_status, n_status;
    logic [FREQ_BITS-1:0] r_ofreq, n_ofreq;
    logic [TAG_BITS-1:0] r_otag, n_otag;
    logic [AW-1:0]       r_fpos, n_fpos;

    logic                 accept;
    logic                 full;
    logic [FREQ_BITS-1:0] rd_freq;
    logic [TAG_BITS-1:0]  rd_tag;
    logic [CW:0]          lc, rc, cnt_x;
    logic                 lc_ok, rc_ok;
    logic [AW-1:0]        parent;
    logic [AW-1:0]        last;
    logic [CW-1:0]        fnext;
    logic                 fnext_ok;
    logic                 match;
    logic [FREQ_BITS-1:0] cmp_a, cmp_b;
    logic                 gt;
    logic                 dn_take_r;
    logic                 dn_move;
    logic [DW-1:0]        dn_entry;

    assign accept   = i_valid && (r_state == S_IDLE);
    assign full     = (r_count == CW'(HEAP_DEPTH));
    assign rd_freq  = i_rdata[DW-1:TAG_BITS];
    assign rd_tag   = i_rdata[TAG_BITS-1:0];
    assign lc       = (CW+1)'({r_pos, 1'b1});
    assign rc       = lc + (CW+1)'(1);
    assign cnt_x    = (CW+1)'(r_count);
    assign lc_ok    = lc < cnt_x;
    assign rc_ok    = rc < cnt_x;
    assign parent   = (r_pos - AW'(1)) >> 1;
    assign last     = AW'(r_count - CW'(1));
    assign fnext    = CW'(r_pos) + CW'(1);
    assign fnext_ok = fnext < r_count;
    assign match    = (rd_tag == r_cur[TAG_BITS-1:0]);

    // single shared magnitude comparator
    always_comb begin
        cmp_a = r_cur[DW-1:TAG_BITS];
        cmp_b = rd_freq;
        case (r_state)
            S_DN_RDR: begin
                cmp_a = rd_freq;
                cmp_b = r_cur[DW-1:TAG_BITS];
            end
            S_DN_CMP: begin
                cmp_a = rd_freq;
                cmp_b = r_best[DW-1:TAG_BITS];
            end
            default: begin
                cmp_a = r_cur[DW-1:TAG_BITS];
                cmp_b = rd_freq;
            end
        endcase
    end

    assign gt        = cmp_a > cmp_b;
    assign dn_take_r = r_rc_ok && gt;
    assign dn_move   = dn_take_r || r_best_child;
    assign dn_entry  = dn_take_r ? i_rdata : (r_best_child ? r_best : r_cur);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_cmd)
                        CMD_INSERT:  n_state = full ? S_DONE : S_UP_RD;
                        CMD_EXTRACT: n_state = (r_count == '0) ? S_DONE : S_EX_RDL;
                        CMD_FIND:    n_state = (r_count == '0) ? S_DONE : S_FD_CMP;
                        default:     n_state = S_DONE;
                    endcase
                end
            end
            S_UP_RD:    n_state = (r_pos == '0) ? S_DONE : S_UP_CMP;
            S_UP_CMP:   n_state = gt ? S_UP_RD : S_DONE;
            S_EX_RDL:   n_state = S_EX_LD;
            S_EX_LD:    n_state = S_DN_START;
            S_DN_START: n_state = lc_ok ? S_DN_RDR : S_DONE;
            S_DN_RDR:   n_state = S_DN_CMP;
            S_DN_CMP:   n_state = dn_move ? S_DN_START : S_DONE;
            S_FD_CMP:   n_state = (!match && fnext_ok) ? S_FD_CMP : S_DONE;
            S_DONE:     n_state = i_res_take ? S_IDLE : S_DONE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_mem_ctl   = '0;
        o_waddr     = r_pos;
        o_wdata     = r_cur;
        o_raddr     = '0;
        o_stall     = (r_state != S_IDLE);
        o_res_valid = (r_state == S_DONE);
        unique case (r_state)
            S_IDLE: begin
                o_mem_ctl.rd = i_valid && ((i_cmd == CMD_EXTRACT) || (i_cmd == CMD_FIND));
            end
            S_UP_RD: begin
                if (r_pos == '0) begin
                    o_mem_ctl.wr = 1'b1;
                end else begin
                    o_mem_ctl.rd = 1'b1;
                    o_raddr      = parent;
                end
            end
            S_UP_CMP: begin
                o_mem_ctl.wr = 1'b1;
                o_wdata      = gt ? i_rdata : r_cur;
            end
            S_EX_RDL: begin
                o_mem_ctl.rd = 1'b1;
                o_raddr      = last;
            end
            S_DN_START: begin
                if (lc_ok) begin
                    o_mem_ctl.rd = 1'b1;
                    o_raddr      = lc[AW-1:0];
                end else begin
                    o_mem_ctl.wr = 1'b1;
                end
            end
            S_DN_RDR: begin
                o_mem_ctl.rd = rc_ok;
                o_raddr      = rc[AW-1:0];
            end
            S_DN_CMP: begin
                o_mem_ctl.wr = 1'b1;
                o_wdata      = dn_entry;
            end
            S_FD_CMP: begin
                o_mem_ctl.rd = !match && fnext_ok;
                o_raddr      = fnext[AW-1:0];
            end
            default: begin
                o_mem_ctl = '0;
            end
        endcase
    end

    always_comb begin
        n_count      = r_count;
        n_pos        = r_pos;
        n_cur        = r_cur;
        n_best       = r_best;
        n_best_idx   = r_best_idx;
        n_best_child = r_best_child;
        n_rc_ok      = r_rc_ok;
        n_status     = r_status;
        n_ofreq      = r_ofreq;
        n_otag       = r_otag;
        n_fpos       = r_fpos;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_status = ST_OK;
                    n_ofreq  = '0;
                    n_otag   = '0;
                    n_fpos   = '0;
                    n_cur    = {i_key_freq, i_item_tag};
                    n_pos    = '0;
                    case (i_cmd)
                        CMD_INSERT: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_pos   = AW'(r_count);
                                n_count = r_count + CW'(1);
                            end
                        end
                        CMD_EXTRACT: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end
                        end
                        CMD_FIND: begin
                            if (r_count == '0) begin
                                n_status = ST_NOT_FOUND;
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            S_UP_CMP: begin
                if (gt) begin
                    n_pos = parent;
                end
            end
            S_EX_RDL: begin
                n_ofreq = rd_freq;
                n_otag  = rd_tag;
            end
            S_EX_LD: begin
                n_cur   = i_rdata;
                n_count = r_count - CW'(1);
                n_pos   = '0;
            end
            S_DN_RDR: begin
                n_rc_ok    = rc_ok;
                n_best_idx = lc[AW-1:0];
                if (gt) begin
                    n_best       = i_rdata;
                    n_best_child = 1'b1;
                end else begin
                    n_best       = r_cur;
                    n_best_child = 1'b0;
                end
            end
            S_DN_CMP: begin
                if (dn_take_r) begin
                    n_pos = rc[AW-1:0];
                end else if (r_best_child) begin
                    n_pos = r_best_idx;
                end
            end
            S_FD_CMP: begin
                if (match) begin
                    n_fpos = r_pos;
                end else if (fnext_ok) begin
                    n_pos = fnext[AW-1:0];
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_cur        <= n_cur;
        r_best       <= n_best;
        r_best_idx   <= n_best_idx;
        r_best_child <= n_best_child;
        r_rc_ok      <= n_rc_ok;
        r_status     <= n_status;
        r_ofreq      <= n_ofreq;
        r_otag       <= n_otag;
        r_fpos       <= n_fpos;
    end

    assign o_status     = r_status;
    assign o_out_freq   = r_ofreq;
    assign o_out_tag    = r_otag;
    assign o_found_pos  = r_fpos;
    assign o_fill_count = r_count;

endmodule

`default_nettype wire

// File: hdl/max_heap_priority_queue_unit.sv
// Max-heap priority queue. Insert sifts the new entry up from the first free position;
// extract returns the root and sifts the last entry down from the root; find scans from
// position 0 and reports the first match or not found; refused, empty and unused commands
// go straight to a result. One request at a time: new requests stall until the result is
// taken into the output stage; the single read port and shared comparator set this.
// Synchronous active-low reset clears sequencer, fill count and output valid; store kept.
`default_nettype none

module max_heap_priority_queue_unit
    import hpq_pkg::*;
#(
    parameter int HEAP_DEPTH = HEAP_DEPTH_DEF,
    parameter int FREQ_BITS  = FREQ_BITS_DEF,
    parameter int TAG_BITS   = TAG_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [1:0]                      i_cmd,
    input  wire logic [FREQ_BITS-1:0]            i_key_freq,
    input  wire logic [TAG_BITS-1:0]             i_item_tag,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic      [1:0]                      o_status,
    output logic      [FREQ_BITS-1:0]            o_out_freq,
    output logic      [TAG_BITS-1:0]             o_out_tag,
    output logic      [$clog2(HEAP_DEPTH)-1:0]   o_found_pos,
    output logic      [$clog2(HEAP_DEPTH+1)-1:0] o_fill_count
);

    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int DW = FREQ_BITS + TAG_BITS;

    t_mem_ctl             w_mem_ctl;
    logic [AW-1:0]        w_waddr, w_raddr;
    logic [DW-1:0]        w_wdata, w_rdata;
    logic                 w_res_valid;
    logic                 w_res_take;
    t_status              w_status;
    logic [FREQ_BITS-1:0] w_out_freq;
    logic [TAG_BITS-1:0]  w_out_tag;
    logic [AW-1:0]        w_found_pos;
    logic [CW-1:0]        w_fill_count;

    logic                 r_o_valid, n_o_valid;
    t_status              r_o_status;
    logic [FREQ_BITS-1:0] r_o_freq;
    logic [TAG_BITS-1:0]  r_o_tag;
    logic [AW-1:0]        r_o_pos;
    logic [CW-1:0]        r_o_fill;

    hpq_seq #(
        .HEAP_DEPTH(HEAP_DEPTH),
        .FREQ_BITS (FREQ_BITS),
        .TAG_BITS  (TAG_BITS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_cmd       (i_cmd),
        .i_key_freq  (i_key_freq),
        .i_item_tag  (i_item_tag),
        .o_res_valid (w_res_valid),
        .i_res_take  (w_res_take),
        .o_status    (w_status),
        .o_out_freq  (w_out_freq),
        .o_out_tag   (w_out_tag),
        .o_found_pos (w_found_pos),
        .o_fill_count(w_fill_count),
        .o_mem_ctl   (w_mem_ctl),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_raddr     (w_raddr),
        .i_rdata     (w_rdata)
    );

    hpq_mem #(
        .HEAP_DEPTH(HEAP_DEPTH),
        .ENTRY_BITS(DW)
    ) u_mem (
        .i_clk  (i_clk),
        .i_ctl  (w_mem_ctl),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // output stage: loads when empty or being drained
    assign w_res_take = w_res_valid && (!r_o_valid || !i_stall);

    always_comb begin
        n_o_valid = r_o_valid;
        if (w_res_take) begin
            n_o_valid = 1'b1;
        end else if (!i_stall) begin
            n_o_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_take) begin
            r_o_status <= w_status;
            r_o_freq   <= w_out_freq;
            r_o_tag    <= w_out_tag;
            r_o_pos    <= w_found_pos;
            r_o_fill   <= w_fill_count;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_status     = r_o_status;
    assign o_out_freq   = r_o_freq;
    assign o_out_tag    = r_o_tag;
    assign o_found_pos  = r_o_pos;
    assign o_fill_count = r_o_fill;

`ifndef SYNTHESIS
    a_wr_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_ctl.wr |-> o_stall)
        else $error("store written while idle");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fill_count <= CW'(HEAP_DEPTH))
        else $error("fill count beyond depth");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("request accepted without going busy");

    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_stall |=> (w_fill_count == $past(w_fill_count)) || $past(i_valid))
        else $error("fill count moved while idle");
`endif

endmodule

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the max-heap priority queue with a built-in heap predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hpq_pkg::*;

    localparam int DEPTH       = HEAP_DEPTH_DEF;
    localparam int FW          = FREQ_BITS_DEF;
    localparam int TW          = TAG_BITS_DEF;
    localparam int POS_W       = $clog2(HEAP_DEPTH_DEF);
    localparam int FILL_W      = $clog2(HEAP_DEPTH_DEF + 1);
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int CALM_TAIL   = 150;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [TW-1:0] ABSENT_TAG = '1;

    typedef struct {
        logic [1:0]    cmd;
        logic [FW-1:0] freq;
        logic [TW-1:0] tag;
        bit            settle;
    } t_heap_request;

    typedef struct {
        t_status         status;
        logic [FW-1:0]   freq;
        logic [TW-1:0]   tag;
        logic [POS_W-1:0] pos;
        logic [FILL_W-1:0] fill;
    } t_heap_reply;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_stall;
    logic [1:0]        req_cmd = '0;
    logic [FW-1:0]     req_freq = '0;
    logic [TW-1:0]     req_tag = '0;
    logic              resp_valid;
    logic              resp_stall = 1'b0;
    logic [1:0]        resp_status;
    logic [FW-1:0]     resp_freq;
    logic [TW-1:0]     resp_tag;
    logic [POS_W-1:0]  resp_pos;
    logic [FILL_W-1:0] resp_fill;

    t_heap_request cmd_backlog[$];
    t_heap_reply   due_responses[$];

    logic [FW-1:0] heap_key[DEPTH];
    logic [TW-1:0] heap_id[DEPTH];
    int held = 0;
    int est_count = 0;
    int issued = 0;
    int failures = 0;
    int cycle_count = 0;
    int gap_left = 0;
    int stall_left = 0;

    max_heap_priority_queue_unit DUT (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_valid      (req_valid),
        .o_stall      (req_stall),
        .i_cmd        (req_cmd),
        .i_key_freq   (req_freq),
        .i_item_tag   (req_tag),
        .o_valid      (resp_valid),
        .i_stall      (resp_stall),
        .o_status     (resp_status),
        .o_out_freq   (resp_freq),
        .o_out_tag    (resp_tag),
        .o_found_pos  (resp_pos),
        .o_fill_count (resp_fill)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic bit idle_allowed();
        return cmd_backlog.size() >= CALM_TAIL && (issued / 120) % 4 != 3;
    endfunction

    function automatic void swap_entries(int a, int b);
        logic [FW-1:0] k;
        logic [TW-1:0] t;
        k = heap_key[a];
        t = heap_id[a];
        heap_key[a] = heap_key[b];
        heap_id[a] = heap_id[b];
        heap_key[b] = k;
        heap_id[b] = t;
    endfunction

    // Applies one accepted request to the heap copy and queues the reply it must produce.
    function automatic void apply_heap_cmd(logic [1:0] cmd, logic [FW-1:0] freq,
                                           logic [TW-1:0] tag);
        t_heap_reply r;
        int pos, up, best, lc, rc;
        r.status = ST_OK;
        r.freq = '0;
        r.tag = '0;
        r.pos = '0;
        case (cmd)
            CMD_INSERT: begin
                if (held >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    heap_key[held] = freq;
                    heap_id[held] = tag;
                    pos = held;
                    held++;
                    while (pos > 0) begin
                        up = (pos - 1) / 2;
                        if (heap_key[up] < heap_key[pos]) begin
                            swap_entries(up, pos);
                            pos = up;
                        end else begin
                            break;
                        end
                    end
                end
            end
            CMD_EXTRACT: begin
                if (held == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.freq = heap_key[0];
                    r.tag = heap_id[0];
                    heap_key[0] = heap_key[held - 1];
                    heap_id[0] = heap_id[held - 1];
                    held--;
                    pos = 0;
                    forever begin
                        best = pos;
                        lc = 2 * pos + 1;
                        rc = 2 * pos + 2;
                        if (lc < held && heap_key[lc] > heap_key[best]) best = lc;
                        if (rc < held && heap_key[rc] > heap_key[best]) best = rc;
                        if (best == pos) break;
                        swap_entries(pos, best);
                        pos = best;
                    end
                end
            end
            CMD_FIND: begin
                r.status = ST_NOT_FOUND;
                for (int i = 0; i < held; i++) begin
                    if (heap_id[i] == tag) begin
                        r.status = ST_OK;
                        r.pos = POS_W'(i);
                        break;
                    end
                end
            end
            default: ;
        endcase
        r.fill = FILL_W'(held);
        due_responses.push_back(r);
    endfunction

    function automatic void compare_field(string name, longint unsigned want,
                                          longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            failures++;
        end
    endfunction

    // Request driver
    always @(posedge clk) begin
        t_heap_request nxt;
        if (!rst_n) begin
            req_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (req_valid && !req_stall) begin
                apply_heap_cmd(req_cmd, req_freq, req_tag);
                issued++;
                if (idle_allowed() && $urandom_range(0, 4) == 0)
                    gap_left = $urandom_range(1, 14);
            end
            if (req_valid && req_stall) begin
                // request held until taken
            end else if (gap_left > 0) begin
                req_valid <= 1'b0;
                gap_left--;
            end else if (cmd_backlog.size() != 0 &&
                         !(cmd_backlog[0].settle && due_responses.size() != 0)) begin
                nxt = cmd_backlog.pop_front();
                req_valid <= 1'b1;
                req_cmd <= nxt.cmd;
                req_freq <= nxt.freq;
                req_tag <= nxt.tag;
            end else begin
                req_valid <= 1'b0;
            end
        end
    end

    // Reply monitor and receiver stall
    always @(posedge clk) begin
        t_heap_reply r;
        if (!rst_n) begin
            resp_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (resp_valid && !resp_stall) begin
                if (due_responses.size() == 0) begin
                    $display("%0t: unexpected reply, expected none actual status %0h",
                             $time, resp_status);
                    failures++;
                end else begin
                    r = due_responses.pop_front();
                    compare_field("status", 64'(r.status), 64'(resp_status));
                    compare_field("out_freq", 64'(r.freq), 64'(resp_freq));
                    compare_field("out_tag", 64'(r.tag), 64'(resp_tag));
                    compare_field("found_pos", 64'(r.pos), 64'(resp_pos));
                    compare_field("fill_count", 64'(r.fill), 64'(resp_fill));
                end
            end
            if (stall_left > 0) begin
                resp_stall <= 1'b1;
                stall_left--;
            end else begin
                resp_stall <= 1'b0;
                if (idle_allowed() && $urandom_range(0, 7) == 0)
                    stall_left = $urandom_range(1, 14);
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [FW-1:0] pick_freq();
        case ($urandom_range(0, 3))
            0: return FW'($urandom_range(0, 7));
            1: return $urandom_range(0, 1) ? '1 : '0;
            default: return FW'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    function automatic logic [TW-1:0] pick_tag();
        if ($urandom_range(0, 9) < 6) return TW'($urandom_range(0, 31));
        return TW'($urandom_range(0, 16'hFFFE));
    endfunction

    task automatic add_item(logic [1:0] cmd, logic [FW-1:0] freq, logic [TW-1:0] tag,
                            bit settle = 1'b0);
        t_heap_request q;
        q.cmd = cmd;
        q.freq = freq;
        q.tag = tag;
        q.settle = settle;
        cmd_backlog.push_back(q);
        if (cmd == CMD_INSERT && est_count < DEPTH) est_count++;
        if (cmd == CMD_EXTRACT && est_count > 0) est_count--;
    endtask

    task automatic add_random(int w_ins, int w_ext, int w_find);
        int r;
        logic [1:0] cmd;
        r = $urandom_range(0, 99);
        if (r < w_ins) cmd = CMD_INSERT;
        else if (r < w_ins + w_ext) cmd = CMD_EXTRACT;
        else if (r < w_ins + w_ext + w_find) cmd = CMD_FIND;
        else cmd = CMD_UNUSED;
        add_item(cmd, pick_freq(), pick_tag());
    endtask

    initial begin
        // directed: empty heap, unused code, extremes, ties, duplicate tags
        add_item(CMD_EXTRACT, 16'h1234, 16'h5678);
        add_item(CMD_FIND, 16'h0000, 16'h0000);
        add_item(CMD_UNUSED, 16'hFFFF, 16'hFFFF);
        add_item(CMD_INSERT, 16'h0000, 16'h0000);
        add_item(CMD_INSERT, 16'hFFFF, 16'hFFFF);
        add_item(CMD_INSERT, 16'h8000, 16'h1234);
        add_item(CMD_INSERT, 16'h8000, 16'h4321);
        add_item(CMD_INSERT, 16'h8000, 16'h1234);
        add_item(CMD_FIND, 16'hAAAA, 16'h1234);
        add_item(CMD_FIND, 16'h5555, 16'hBEEF);
        add_item(CMD_UNUSED, 16'hA5A5, 16'h5A5A);
        add_item(CMD_EXTRACT, 16'hFFFF, 16'h0000);
        add_item(CMD_EXTRACT, 16'h0000, 16'hFFFF);
        add_item(CMD_INSERT, 16'hFFFF, 16'h0000);
        add_item(CMD_FIND, 16'h0000, 16'h0000);
        add_item(CMD_FIND, 16'h0000, 16'hFFFF);
        repeat (5) add_item(CMD_EXTRACT, 16'h0F0F, 16'hF0F0);
        add_item(CMD_FIND, 16'h0000, 16'h4321);

        // random mix around a small heap
        repeat (250) add_random(45, 35, 15);

        // fill to capacity, then refused inserts and full-length scans
        add_item(CMD_INSERT, pick_freq(), pick_tag(), 1'b1);
        while (est_count < DEPTH) add_random(93, 0, 5);
        add_item(CMD_INSERT, pick_freq(), pick_tag(), 1'b1);
        repeat (3) add_item(CMD_INSERT, pick_freq(), pick_tag());
        add_item(CMD_FIND, pick_freq(), ABSENT_TAG);
        add_item(CMD_FIND, pick_freq(), pick_tag());
        add_item(CMD_EXTRACT, pick_freq(), pick_tag());
        add_item(CMD_INSERT, pick_freq(), pick_tag());
        add_item(CMD_INSERT, pick_freq(), pick_tag());

        // drain-weighted mix from a deep heap
        repeat (600) add_random(15, 70, 10);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || req_valid) @(posedge clk);
        while (due_responses.size() != 0) @(posedge clk);
        repeat (64) @(posedge clk);

        if (failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
